// ===== src/fcr_pkg.sv =====
// fcr_pkg: types and constants shared by the framed command receiver.
// No dependencies; imported by fcr_frame_check and framed_command_receiver.
`timescale 1ns / 1ps

package fcr_pkg;

    localparam int unsigned POS_W      = 6;   // byte position counter
    localparam int unsigned FRAME_KEPT = 5;   // frame bytes 1..5 are kept
    localparam int unsigned KEPT_IDX_W = 3;

    localparam logic [7:0]  START_RESET    = 8'hAA;
    localparam logic [7:0]  END_RESET      = 8'hAB;
    localparam logic [7:0]  WORK_KEY_RESET = 8'h00;

    localparam logic [7:0]  SUM_MASK       = 8'h7F;
    localparam logic [4:0]  TIME_FIELD_W5  = 5'h1F;
    localparam logic [15:0] SECS_PER_MIN   = 16'd60;

    localparam logic [7:0]  UPD_KEY        = 8'hA5;
    localparam logic [7:0]  UPD_VERSION_B3 = 8'h01;
    localparam logic [7:0]  UPD_START_B3   = 8'h02;
    localparam logic [7:0]  UPD_B4         = 8'h01;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_BADSUM   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } fcr_status_t;

    typedef enum logic [1:0] {
        UPD_NONE    = 2'd0,
        UPD_VERSION = 2'd1,
        UPD_START   = 2'd2
    } fcr_update_t;

    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_WORK_KEY   = 2'd2
    } fcr_cfg_idx_t;

    // bytes 1..5 of a frame, element 0 is byte 1
    typedef logic [FRAME_KEPT-1:0][7:0] fcr_frame_t;

    // decode of a closing frame
    typedef struct packed {
        logic        sum_ok;
        logic        key_hit;
        logic        upd_hit;
        fcr_update_t upd_val;
        logic [15:0] run_time;
    } fcr_check_t;

endpackage

// ===== src/framed_command_receiver.sv =====
// A byte passes through the input register; its result (if any) is then registered and shown on m_tvalid.
// Throughput: one byte per cycle; the input register and the frame state update
// both advance every cycle unless a result waits on a stalled m_tready.
// Reset (aresetn low, synchronous): returns to hunting, clears the kept frame bytes,
// key, run time and update request, and loads the register reset values.
// Depends on fcr_pkg and fcr_frame_check.
`timescale 1ns / 1ps

module framed_command_receiver
    import fcr_pkg::*;
#(
    parameter int unsigned FRAME_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] key_code, [23:8] run_time_seconds,
                                    // [25:24] update_request, [31:26] zero
    output logic [1:0]  m_tuser,    // [1:0] frame_status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(FRAME_DEPTH);
    localparam logic [POS_W-1:0] LAST_KEPT = POS_W'(FRAME_KEPT);

    // configuration
    logic [7:0]       start_reg;
    logic [7:0]       end_reg;
    logic [7:0]       wkey_reg;

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    // frame state
    logic [POS_W-1:0] pos_reg,   pos_next;
    fcr_frame_t       frame_reg, frame_next;
    logic [7:0]       key_reg,   key_next;
    logic [15:0]      run_reg,   run_next;
    fcr_update_t      pend_reg,  pend_next;

    // result register; key, run time and request come from the state,
    // which cannot move while a result is held
    logic             m_valid_reg;
    fcr_status_t      status_reg, status_next;

    logic             out_free;
    logic             advance;
    logic             hunting;
    logic             overrun;
    logic             closing;
    logic             load_out;
    logic [KEPT_IDX_W-1:0] kept_idx;
    fcr_check_t       check;

    assign cfg_ready = 1'b1;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    assign hunting  = (pos_reg == '0);
    assign overrun  = !hunting && (pos_reg >= DEPTH_POS);
    assign closing  = !hunting && !overrun && (in_byte_reg == end_reg);
    assign load_out = advance && (overrun || closing);
    assign kept_idx = KEPT_IDX_W'(pos_reg - POS_W'(1));

    always_comb begin
        frame_next = frame_reg;
        if (!hunting && !overrun && pos_reg <= LAST_KEPT) begin
            frame_next[kept_idx] = in_byte_reg;
        end
    end

    fcr_frame_check u_check (
        .frame    (frame_next),
        .work_key (wkey_reg),
        .check    (check)
    );

    always_comb begin
        pos_next    = pos_reg;
        key_next    = key_reg;
        run_next    = run_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        if (advance) begin
            if (hunting) begin
                if (in_byte_reg == start_reg) begin
                    pos_next = POS_W'(1);
                end
            end else if (overrun) begin
                pos_next    = '0;
                status_next = STATUS_OVERFLOW;
            end else if (closing) begin
                pos_next = '0;
                if (check.sum_ok) begin
                    status_next = STATUS_GOOD;
                    key_next    = frame_next[1];
                    if (check.key_hit) begin
                        run_next = check.run_time;
                    end
                    if (check.upd_hit) begin
                        pend_next = check.upd_val;
                    end
                end else begin
                    status_next = STATUS_BADSUM;
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_RESET;
            end_reg   <= END_RESET;
            wkey_reg  <= WORK_KEY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (fcr_cfg_idx_t'(cfg_index))
                CFG_START_BYTE: start_reg <= cfg_data;
                CFG_END_BYTE:   end_reg   <= cfg_data;
                CFG_WORK_KEY:   wkey_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            frame_reg   <= '0;
            key_reg     <= '0;
            run_reg     <= '0;
            pend_reg    <= UPD_NONE;
            m_valid_reg <= 1'b0;
            status_reg  <= STATUS_GOOD;
        end else begin
            pos_reg    <= pos_next;
            key_reg    <= key_next;
            run_reg    <= run_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
            if (advance) begin
                frame_reg <= frame_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, pend_reg, run_reg, key_reg};

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= DEPTH_POS)
        else $error("byte position beyond frame depth");

    a_hunt_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> pos_reg == '0)
        else $error("receiver not hunting after a frame result");

    a_key_only_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (key_reg != $past(key_reg)) |->
            $past(load_out && closing && check.sum_ok))
        else $error("key code changed without a good frame");

    a_update_code: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == UPD_NONE || pend_reg == UPD_VERSION || pend_reg == UPD_START)
        else $error("invalid update request code");
`endif

endmodule

// ===== src/fcr_frame_check.sv =====
// fcr_frame_check: checksum and command decode of the kept frame bytes.
// Purely combinational; depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_frame_check
    import fcr_pkg::*;
(
    input  fcr_frame_t  frame,
    input  logic [7:0]  work_key,
    output fcr_check_t  check
);

    logic [7:0] sum;
    logic [7:0] expect_sum;
    logic [9:0] minutes;

    assign sum        = frame[0] + frame[1] + frame[2] + frame[3];
    assign expect_sum = ~sum & SUM_MASK;
    // byte 4 gives the upper five bits of the minute count, byte 3 the lower
    assign minutes    = {frame[3][4:0] & TIME_FIELD_W5, frame[2][4:0] & TIME_FIELD_W5};

    always_comb begin
        check.sum_ok   = (expect_sum == frame[4]);
        check.key_hit  = (frame[1] == work_key);
        check.run_time = 16'(minutes) * SECS_PER_MIN;
        check.upd_hit  = 1'b0;
        check.upd_val  = UPD_NONE;
        if (frame[1] == UPD_KEY && frame[3] == UPD_B4) begin
            if (frame[2] == UPD_VERSION_B3) begin
                check.upd_hit = 1'b1;
                check.upd_val = UPD_VERSION;
            end else if (frame[2] == UPD_START_B3) begin
                check.upd_hit = 1'b1;
                check.upd_val = UPD_START;
            end
        end
    end

endmodule
